[rtl/dam_pkg.sv]
// Shared types, constants and helper functions for the Gregorian date plus months pipeline.
// Used by dam_civil, dam_month, date_add_months_with_roll_top and dam_checker. No dependencies.
`default_nettype none

package dam_pkg;

  // Field widths
  localparam int DAY_W      = 24;
  localparam int DELTA_W    = 17;
  localparam int RES_W      = 25;
  localparam int MODE_W     = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  // Roll mode codes
  localparam logic [MODE_W-1:0] ROLL_MISSING  = 3'd0;
  localparam logic [MODE_W-1:0] ROLL_BACK     = 3'd1;
  localparam logic [MODE_W-1:0] ROLL_FWD      = 3'd2;
  localparam logic [MODE_W-1:0] ROLL_FWD_ADD  = 3'd3;
  localparam logic [MODE_W-1:0] ROLL_BACK_ADD = 3'd4;
  localparam logic [MODE_W-1:0] ROLL_RESET    = ROLL_BACK;

  // Internal widths
  localparam int Z_W      = 25;  // biased day count, always positive
  localparam int ERA_W    = 7;   // biased 400-year era
  localparam int DOE_W    = 18;  // day of era, 0..146096
  localparam int YOE_W    = 9;   // year of era, 0..399
  localparam int DOY_W    = 9;   // day of March-based year, 0..365
  localparam int MON_W    = 4;
  localparam int DAYM_W   = 5;
  localparam int YR_W     = 16;  // biased year
  localparam int TOT_W    = 20;  // biased month count
  localparam int Q1460_W  = 7;
  localparam int Q400_W   = 8;
  localparam int EPROD_W  = 25;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;
  localparam int MONTHS_YR = 12;

  // Calendar constants and biases
  localparam longint EPOCH_SHIFT = 719468;   // days from 0000-03-01 to 1970-01-01
  localparam longint DAYS_ERA    = 146097;
  localparam longint YRS_ERA     = 400;
  localparam longint ERA_BIAS    = 53;       // keeps the shifted day count positive
  localparam longint Z_OFS       = EPOCH_SHIFT + ERA_BIAS * DAYS_ERA;
  localparam longint YR_BIAS     = 32768;    // year offset carried between stages
  localparam longint YEAR_OFS    = YR_BIAS - ERA_BIAS * YRS_ERA;
  localparam longint ALIGN_ADD   = 32;       // YR_BIAS + ALIGN_ADD is a multiple of 400
  localparam longint ERA2_BIAS   = (YR_BIAS + ALIGN_ADD) / YRS_ERA;
  localparam longint DAYS_OFS    = ERA2_BIAS * DAYS_ERA + EPOCH_SHIFT;
  localparam longint DOE_LAST    = DAYS_ERA - 1;
  localparam longint DAYS_CENT   = 36524;

  // Exact reciprocals: q = (x * M) >> K for every x below 2**n,
  // with K = n + ceil(log2 d) and M = ceil(2**K / d).
  localparam int     ERA_K   = Z_W + 18;
  localparam longint ERA_M   = ((longint'(1) << ERA_K) + DAYS_ERA - 1) / DAYS_ERA;
  localparam int     ERA_MW  = $clog2(ERA_M + 1);

  localparam int     C4_K    = DOE_W + 11;
  localparam longint C4_M    = ((longint'(1) << C4_K) + 1460 - 1) / 1460;
  localparam int     C4_MW   = $clog2(C4_M + 1);

  localparam int     Y365_K  = DOE_W + 9;
  localparam longint Y365_M  = ((longint'(1) << Y365_K) + 365 - 1) / 365;
  localparam int     Y365_MW = $clog2(Y365_M + 1);

  localparam int     M12_K   = TOT_W + 4;
  localparam longint M12_M   = ((longint'(1) << M12_K) + MONTHS_YR - 1) / MONTHS_YR;
  localparam int     M12_MW  = $clog2(M12_M + 1);

  localparam int     M400_K  = YR_W + 9;
  localparam longint M400_M  = ((longint'(1) << M400_K) + YRS_ERA - 1) / YRS_ERA;
  localparam int     M400_MW = $clog2(M400_M + 1);

  // Input transaction into the pipeline
  typedef struct packed {
    logic                      valid;
    logic [DAY_W-1:0]          day_count;
    logic [DELTA_W-1:0]        month_delta;
    logic                      missing;
  } dam_in_t;

  // Civil date handed from the decode half to the month half
  typedef struct packed {
    logic                      valid;
    logic [YR_W-1:0]           year;    // year + YR_BIAS
    logic [MON_W-1:0]          month;   // 1..12
    logic [DAYM_W-1:0]         day;     // 1..31
    logic [DELTA_W-1:0]        delta;
    logic                      missing;
  } dam_civil_t;

  // Result leaving the pipeline
  typedef struct packed {
    logic                      valid;
    logic [RES_W-1:0]          days;
    logic                      missing;
  } dam_res_t;

  // First day (0-based) of each month in a year starting in March
  function automatic logic [DOY_W-1:0] doy_start(input logic [MON_W-1:0] mp);
    logic [DOY_W-1:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Number of whole centuries in a year of era
  function automatic logic [1:0] cent_cnt(input logic [YOE_W-1:0] yoe);
    return 2'(yoe >= YOE_W'(100)) + 2'(yoe >= YOE_W'(200)) + 2'(yoe >= YOE_W'(300));
  endfunction

  // Length of a calendar month (1..12)
  function automatic logic [DAYM_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAYM_W-1:0] r;
    unique case (m)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/date_add_months_with_roll_top.sv]
// Top level: Gregorian date plus months with roll, streaming in and out.
// Depends on dam_pkg, dam_civil and dam_month.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+-----------------------------------------
//   s_axis  | in  | s_axis_tvalid/tready    | tdata: day_count, month_delta; tuser: miss
//   m_axis  | out | m_axis_tvalid/tready    | tdata: result_days; tuser: result_missing
//   cfg     | in  | cfg_valid/cfg_ready     | cfg_data: roll_mode
//
// One transaction per cycle sustained while the output skid spare is free; from acceptance to
// m_axis_tvalid an item passes ten stages of day-to-date decode, ten of month add and re-encode
// and one output register. Throughput is set by the pipeline, one item per stage.
// rst is synchronous; it clears the valid bits, the output skid and sets roll_mode to 1.
// A stall on m_axis freezes the whole pipeline once the two-entry output skid fills;
// s_axis_tready is a register output and cfg_ready is always high.
`default_nettype none

module date_add_months_with_roll_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dam_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [23:0] day_count, [40:24] month_delta
  input  logic                            s_axis_tuser,  // [0] input_missing
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [dam_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [24:0] result_days
  output logic                            m_axis_tuser,  // [0] result_missing
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dam_pkg::MODE_W-1:0]      cfg_data
);
  import dam_pkg::*;

  logic [MODE_W-1:0] roll_mode;
  logic              en;
  dam_in_t           in_item;
  dam_civil_t        civil;
  dam_res_t          res;
  logic              push;
  logic              out_valid, spare_valid;
  logic [RES_W-1:0]  out_days, spare_days;
  logic              out_miss, spare_miss;

  // Roll mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_mode <= ROLL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      roll_mode <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // Pipeline moves whenever the skid spare is free
  assign en            = !spare_valid;
  assign s_axis_tready = en;

  always_comb begin
    in_item.valid       = s_axis_tvalid;
    in_item.day_count   = s_axis_tdata[DAY_W-1:0];
    in_item.month_delta = s_axis_tdata[DAY_W +: DELTA_W];
    in_item.missing     = s_axis_tuser;
  end

  dam_civil u_civil (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_item  (in_item),
    .out_item (civil)
  );

  dam_month u_month (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .roll_mode (roll_mode),
    .in_item   (civil),
    .out_item  (res)
  );

  assign push = res.valid && en;

  // Output register with skid spare
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (spare_valid) begin
        out_days <= spare_days;
        out_miss <= spare_miss;
      end else if (push) begin
        out_days <= res.days;
        out_miss <= res.missing;
      end
    end else if (push) begin
      spare_days <= res.days;
      spare_miss <= res.missing;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_days};
  assign m_axis_tuser  = out_miss;

endmodule

`default_nettype wire

[rtl/dam_civil.sv]
// Ten-stage pipeline: signed day count to biased civil year, month and day.
// Depends on dam_pkg.
`default_nettype none

module dam_civil (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  dam_pkg::dam_in_t    in_item,
  output dam_pkg::dam_civil_t out_item
);
  import dam_pkg::*;

  localparam int STAGES = 10;

  logic [STAGES-1:0]  vld;
  logic [DELTA_W-1:0] delta_q [STAGES];
  logic               miss_q  [STAGES];

  logic [Z_W-1:0]     s1_z, s2_z;
  logic [ERA_W-1:0]   s2_era, s3_era, s4_era, s5_era, s6_era, s7_era, s8_era, s9_era;
  logic [DOE_W-1:0]   s3_doe, s4_doe, s5_doe, s6_doe, s7_doe;
  logic [Q1460_W-1:0] s4_c4;
  logic [2:0]         s4_c100;
  logic               s4_c400;
  logic [DOE_W-1:0]   s5_t;
  logic [YOE_W-1:0]   s6_yoe, s7_yoe, s8_yoe, s9_yoe;
  logic [DOE_W-1:0]   s7_p;
  logic [DOY_W-1:0]   s8_doy, s9_doy;
  logic [MON_W-1:0]   s9_mp;
  logic [YR_W-1:0]    s10_year;
  logic [MON_W-1:0]   s10_mon;
  logic [DAYM_W-1:0]  s10_day;

  logic [Z_W+ERA_MW-1:0]    era_prod;
  logic [Z_W-1:0]           era_days;
  logic [DOE_W+C4_MW-1:0]   c4_prod;
  logic [DOE_W+Y365_MW-1:0] y_prod;
  logic [MON_W-1:0]         mp_cnt;
  logic [MON_W-1:0]         mon_c;
  logic [DOY_W-1:0]         day_c;
  logic [YR_W-1:0]          year_c;

  // Valid bits and side fields move with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      delta_q[0] <= in_item.month_delta;
      miss_q[0]  <= in_item.missing;
      for (int i = 1; i < STAGES; i++) begin
        delta_q[i] <= delta_q[i-1];
        miss_q[i]  <= miss_q[i-1];
      end
    end
  end

  // Arithmetic for the stages
  always_comb begin
    era_prod = (Z_W+ERA_MW)'(s1_z) * (Z_W+ERA_MW)'(ERA_M);
    era_days = Z_W'(s2_era) * Z_W'(DAYS_ERA);
    c4_prod  = (DOE_W+C4_MW)'(s3_doe) * (DOE_W+C4_MW)'(C4_M);
    y_prod   = (DOE_W+Y365_MW)'(s5_t) * (DOE_W+Y365_MW)'(Y365_M);
    // month of the March-based year by threshold count
    mp_cnt = '0;
    for (int i = 1; i < MONTHS_YR; i++) begin
      mp_cnt = mp_cnt + MON_W'(s8_doy >= doy_start(MON_W'(i)));
    end
    mon_c  = (s9_mp < MON_W'(10)) ? s9_mp + MON_W'(3) : s9_mp - MON_W'(9);
    day_c  = s9_doy - doy_start(s9_mp) + DOY_W'(1);
    year_c = YR_W'(s9_era) * YR_W'(YRS_ERA) + YR_W'(YEAR_OFS) + YR_W'(s9_yoe)
           + YR_W'(mon_c <= MON_FEB);
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: shift so that the day count is positive
      s1_z <= {in_item.day_count[DAY_W-1], in_item.day_count} + Z_W'(Z_OFS);
      // stage 2: era
      s2_z   <= s1_z;
      s2_era <= era_prod[ERA_K +: ERA_W];
      // stage 3: day of era
      s3_era <= s2_era;
      s3_doe <= DOE_W'(s2_z - era_days);
      // stage 4: leap corrections
      s4_era  <= s3_era;
      s4_doe  <= s3_doe;
      s4_c4   <= c4_prod[C4_K +: Q1460_W];
      s4_c100 <= 3'(s3_doe >= DOE_W'(DAYS_CENT)) + 3'(s3_doe >= DOE_W'(2 * DAYS_CENT))
               + 3'(s3_doe >= DOE_W'(3 * DAYS_CENT)) + 3'(s3_doe >= DOE_W'(DOE_LAST));
      s4_c400 <= (s3_doe == DOE_W'(DOE_LAST));
      // stage 5: corrected day count
      s5_era <= s4_era;
      s5_doe <= s4_doe;
      s5_t   <= s4_doe - DOE_W'(s4_c4) + DOE_W'(s4_c100) - DOE_W'(s4_c400);
      // stage 6: year of era
      s6_era <= s5_era;
      s6_doe <= s5_doe;
      s6_yoe <= y_prod[Y365_K +: YOE_W];
      // stage 7: days before that year
      s7_era <= s6_era;
      s7_doe <= s6_doe;
      s7_yoe <= s6_yoe;
      s7_p   <= DOE_W'(s6_yoe) * DOE_W'(365) + DOE_W'(s6_yoe >> 2) - DOE_W'(cent_cnt(s6_yoe));
      // stage 8: day of year
      s8_era <= s7_era;
      s8_yoe <= s7_yoe;
      s8_doy <= DOY_W'(s7_doe - s7_p);
      // stage 9: month of year
      s9_era <= s8_era;
      s9_yoe <= s8_yoe;
      s9_doy <= s8_doy;
      s9_mp  <= mp_cnt;
      // stage 10: civil fields
      s10_year <= year_c;
      s10_mon  <= mon_c;
      s10_day  <= DAYM_W'(day_c);
    end
  end

  always_comb begin
    out_item.valid   = vld[STAGES-1];
    out_item.year    = s10_year;
    out_item.month   = s10_mon;
    out_item.day     = s10_day;
    out_item.delta   = delta_q[STAGES-1];
    out_item.missing = miss_q[STAGES-1];
  end

endmodule

`default_nettype wire

[rtl/dam_month.sv]
// Ten-stage pipeline: add months, apply the roll mode, convert back to a day count.
// Depends on dam_pkg.
`default_nettype none

module dam_month (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [dam_pkg::MODE_W-1:0] roll_mode,
  input  dam_pkg::dam_civil_t in_item,
  output dam_pkg::dam_res_t   out_item
);
  import dam_pkg::*;

  localparam int STAGES = 10;

  logic [STAGES-1:0] vld;

  logic [TOT_W-1:0]  t1_tot, t2_tot;
  logic [DAYM_W-1:0] t1_day, t2_day, t3_day, t4_day, t5_day, t6_day, t7_day;
  logic              t1_dneg, t2_dneg, t3_dneg, t4_dneg, t5_dneg;
  logic              t1_miss, t2_miss, t3_miss, t4_miss, t5_miss, t6_miss, t7_miss;
  logic              t8_miss, t9_miss;
  logic [YR_W-1:0]   t2_ny, t3_yr, t4_yr, t5_yr, t6_yr;
  logic [YR_W-1:0]   t3_wn, t4_wn, t7_w;
  logic [MON_W-1:0]  t3_mon, t4_mon, t5_mon, t6_mon, t7_mon;
  logic [Q400_W-1:0] t4_q, t7_q, t8_q;
  logic [DAYM_W-1:0] t5_mlen;
  logic [YOE_W-1:0]  t8_yoe;
  logic [DOY_W-1:0]  t8_doy;
  logic [DOE_W-1:0]  t9_doe;
  logic [EPROD_W-1:0] t9_eprod;
  logic [RES_W-1:0]  t10_days;
  logic              t10_miss;

  logic [TOT_W-1:0]         tot_c;
  logic [TOT_W+M12_MW-1:0]  ny_prod;
  logic [YR_W+M400_MW-1:0]  q_prod, q2_prod;
  logic [YOE_W-1:0]         r400;
  logic                     leap;
  logic                     over, fwd, mode_ok;
  logic [YR_W-1:0]          yr_n;
  logic [MON_W-1:0]         mon_n;
  logic [DAYM_W-1:0]        day_n;
  logic                     miss_n;
  logic [YR_W-1:0]          w_c;
  logic [MON_W-1:0]         mp2;
  logic [RES_W:0]           sum_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_item.valid};
    end
  end

  // Month arithmetic, leap test and roll decision
  always_comb begin
    tot_c   = TOT_W'(in_item.year) * TOT_W'(MONTHS_YR) + TOT_W'(in_item.month) - TOT_W'(1)
            + {{(TOT_W-DELTA_W){in_item.delta[DELTA_W-1]}}, in_item.delta};
    ny_prod = (TOT_W+M12_MW)'(t1_tot) * (TOT_W+M12_MW)'(M12_M);
    q_prod  = (YR_W+M400_MW)'(t3_wn) * (YR_W+M400_MW)'(M400_M);
    r400    = YOE_W'(t4_wn - YR_W'(t4_q) * YR_W'(YRS_ERA));
    leap    = (r400[1:0] == 2'b00) && (r400 != YOE_W'(100)) && (r400 != YOE_W'(200))
            && (r400 != YOE_W'(300));

    over    = t5_day > t5_mlen;
    fwd     = 1'b0;
    mode_ok = 1'b1;
    unique case (roll_mode)
      ROLL_MISSING:  mode_ok = 1'b0;
      ROLL_BACK:     fwd = 1'b0;
      ROLL_FWD:      fwd = 1'b1;
      ROLL_FWD_ADD:  fwd = !t5_dneg;
      ROLL_BACK_ADD: fwd = t5_dneg;
      default:       mode_ok = 1'b0;
    endcase
    yr_n   = t5_yr;
    mon_n  = t5_mon;
    day_n  = t5_day;
    miss_n = t5_miss;
    if (over) begin
      if (!mode_ok) begin
        miss_n = 1'b1;
      end else if (fwd) begin
        day_n = DAYM_W'(1);
        if (t5_mon == MON_DEC) begin
          yr_n  = t5_yr + YR_W'(1);
          mon_n = MON_JAN;
        end else begin
          mon_n = t5_mon + MON_W'(1);
        end
      end else begin
        day_n = t5_mlen;
      end
    end

    // back to days: year aligned to a 400-year boundary
    w_c     = t6_yr + YR_W'(ALIGN_ADD) - YR_W'(t6_mon <= MON_FEB);
    q2_prod = (YR_W+M400_MW)'(w_c) * (YR_W+M400_MW)'(M400_M);
    mp2     = (t7_mon > MON_FEB) ? t7_mon - MON_W'(3) : t7_mon + MON_W'(9);
    sum_c   = (RES_W+1)'(t9_eprod) + (RES_W+1)'(t9_doe) - (RES_W+1)'(DAYS_OFS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: biased month count
      t1_tot  <= tot_c;
      t1_day  <= in_item.day;
      t1_dneg <= in_item.delta[DELTA_W-1];
      t1_miss <= in_item.missing;
      // stage 2: new year
      t2_tot  <= t1_tot;
      t2_ny   <= ny_prod[M12_K +: YR_W];
      t2_day  <= t1_day;
      t2_dneg <= t1_dneg;
      t2_miss <= t1_miss;
      // stage 3: new month
      t3_yr   <= t2_ny;
      t3_wn   <= t2_ny + YR_W'(ALIGN_ADD);
      t3_mon  <= MON_W'(t2_tot - TOT_W'(t2_ny) * TOT_W'(MONTHS_YR)) + MON_W'(1);
      t3_day  <= t2_day;
      t3_dneg <= t2_dneg;
      t3_miss <= t2_miss;
      // stage 4: 400-year quotient for the leap test
      t4_q    <= q_prod[M400_K +: Q400_W];
      t4_wn   <= t3_wn;
      t4_yr   <= t3_yr;
      t4_mon  <= t3_mon;
      t4_day  <= t3_day;
      t4_dneg <= t3_dneg;
      t4_miss <= t3_miss;
      // stage 5: month length
      t5_mlen <= month_len(t4_mon, leap);
      t5_yr   <= t4_yr;
      t5_mon  <= t4_mon;
      t5_day  <= t4_day;
      t5_dneg <= t4_dneg;
      t5_miss <= t4_miss;
      // stage 6: roll
      t6_yr   <= yr_n;
      t6_mon  <= mon_n;
      t6_day  <= day_n;
      t6_miss <= miss_n;
      // stage 7: era of the final date
      t7_w    <= w_c;
      t7_q    <= q2_prod[M400_K +: Q400_W];
      t7_mon  <= t6_mon;
      t7_day  <= t6_day;
      t7_miss <= t6_miss;
      // stage 8: year of era and day of year
      t8_q    <= t7_q;
      t8_yoe  <= YOE_W'(t7_w - YR_W'(t7_q) * YR_W'(YRS_ERA));
      t8_doy  <= doy_start(mp2) + DOY_W'(t7_day) - DOY_W'(1);
      t8_miss <= t7_miss;
      // stage 9: day of era and era days
      t9_doe   <= DOE_W'(t8_yoe) * DOE_W'(365) + DOE_W'(t8_yoe >> 2)
                - DOE_W'(cent_cnt(t8_yoe)) + DOE_W'(t8_doy);
      t9_eprod <= EPROD_W'(t8_q) * EPROD_W'(DAYS_ERA);
      t9_miss  <= t8_miss;
      // stage 10: day count
      t10_days <= t9_miss ? '0 : sum_c[RES_W-1:0];
      t10_miss <= t9_miss;
    end
  end

  always_comb begin
    out_item.valid   = vld[STAGES-1];
    out_item.days    = t10_days;
    out_item.missing = t10_miss;
  end

endmodule

`default_nettype wire

[rtl/dam_checker.sv]
// Port-level checks for date_add_months_with_roll_top, attached by bind.
// Depends on dam_pkg for the output width.
`default_nettype none

module dam_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dam_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tuser
);

  // Missing results always carry a zero day count
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("missing result with nonzero days");

  // Stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output changed while stalled");

  // Backpressure on input only while a result waits at the output
  a_bp_needs_out: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // One output transaction drains the skid and reopens the input
  a_bp_release: assert property (@(posedge clk) disable iff (rst)
    (!s_axis_tready && m_axis_tready) |=> s_axis_tready)
    else $error("input still stalled after output drain");

endmodule

bind date_add_months_with_roll_top dam_checker u_dam_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
